// ===== src/ibrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ibrs_pkg
// shared types and constants for the integer-by-rate scaler
// ----------------------------------------------------------------------------
package ibrs_pkg;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
  localparam logic [52:0] HIDDEN_BIT   = 53'h10_0000_0000_0000;
  localparam int          PREC_BITS    = 100;
  localparam int          EXP_BIAS     = 1075;

  localparam logic [63:0] LIM_I64_POS = 64'h7fff_ffff_ffff_fffe;
  localparam logic [63:0] LIM_I64_NEG = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] LIM_I32     = 64'h0000_0000_7fff_ffff;

  // decoded and registered front end of one word
  typedef struct packed {
    logic        is_int;
    logic        i32;
    logic        neg;
    logic        zero;
    logic        fail;
    logic [63:0] cnt;
    logic [63:0] lim;
    logic signed [12:0] exp;
    logic [127:0] prod;
  } ibrs_mid_t;

endpackage

// ===== src/int_by_rate_scaler.sv =====
// ----------------------------------------------------------------------------
// int_by_rate_scaler
// signed count times a double or integer rate, converted to int64 or int32
// ----------------------------------------------------------------------------
// one word in per cycle, each result registered in turn: the first
// register holds the decoded word and the four 32 x 32 partial products, the
// second the summed magnitude product, the third the rounded, scaled and
// range-checked result. busy is never raised, the receiver cannot stall and
// out_valid pulses for one cycle per word. on a failed conversion out_ok is
// low and out_product_value echoes the count.
module int_by_rate_scaler import ibrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic signed [63:0] in_count,
  input  logic [63:0] in_rate_bits,
  input  logic        in_rate_wide,
  output logic        out_valid,
  output logic        out_ok,
  output logic signed [63:0] out_product_value
);

  ibrs_mid_t   mid_r;
  logic        v1_r;
  logic        v2_r;
  logic        ok_c;
  logic [63:0] val_c;

  // fully pipelined, never stalls
  assign busy = 1'b0;

  ibrs_front u_front (
    .clk       (clk),
    .op        (in_op),
    .count     (in_count),
    .rate_bits (in_rate_bits),
    .rate_wide (in_rate_wide),
    .mid_r     (mid_r)
  );

  ibrs_back u_back (
    .mid   (mid_r),
    .ok    (ok_c),
    .value (val_c)
  );

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      out_valid <= v2_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    out_ok <= ok_c;
    out_product_value <= val_c;
  end

endmodule

// ===== src/ibrs_front.sv =====
// ----------------------------------------------------------------------------
// ibrs_front
// decode of the word and magnitude product, two registered stages
// ----------------------------------------------------------------------------
module ibrs_front import ibrs_pkg::*; (
  input  logic              clk,
  input  logic [1:0]        op,
  input  logic [63:0]       count,
  input  logic [63:0]       rate_bits,
  input  logic              rate_wide,
  output ibrs_mid_t         mid_r
);

  ibrs_mid_t   dec_nxt;
  ibrs_mid_t   dec_r;
  ibrs_mid_t   mid_nxt;
  logic [63:0] lh_nxt;
  logic [63:0] hl_nxt;
  logic [63:0] lh_r;
  logic [63:0] hl_r;
  logic [63:0] cnt;
  logic [63:0] mag;
  logic [63:0] mul_b;
  logic [10:0] ebits;
  logic [52:0] sig;

  always_comb begin
    cnt = op[1] ? {{32{count[31]}}, count[31:0]} : count;
    mag = cnt[63] ? (64'd0 - cnt) : cnt;
    ebits = rate_bits[62:52];
    sig = (ebits == 11'd0) ? {1'b0, rate_bits[51:0]} : ({1'b0, rate_bits[51:0]} | HIDDEN_BIT);
    mul_b = op[0] ? rate_bits : {11'd0, sig};
    dec_nxt.is_int = op[0];
    dec_nxt.i32 = op[1];
    dec_nxt.cnt = cnt;
    if (op[0]) begin
      dec_nxt.neg = cnt[63];
      dec_nxt.zero = (cnt == 64'd0) || (rate_bits == 64'd0 && !rate_wide);
      dec_nxt.fail = rate_wide || (op[1] ? (rate_bits[63:31] != 33'd0) : rate_bits[63]);
    end else begin
      dec_nxt.neg = cnt[63] ^ rate_bits[63];
      dec_nxt.zero = 1'b0;
      dec_nxt.fail = (ebits == EXP_ALL_ONES);
    end
    dec_nxt.lim = op[1] ? LIM_I32 : (dec_nxt.neg ? LIM_I64_NEG : LIM_I64_POS);
    dec_nxt.exp = (ebits == 11'd0) ? -13'sd1074 : ($signed({2'b00, ebits}) - 13'(EXP_BIAS));
    // 64 x 64 split into four 32 x 32 partial products; the aligned pair
    // goes straight into the product field, the cross terms are registered apart and added in the sum stage
    dec_nxt.prod = {64'(mag[63:32]) * 64'(mul_b[63:32]),
                    64'(mag[31:0]) * 64'(mul_b[31:0])};
    lh_nxt = 64'(mag[31:0]) * 64'(mul_b[63:32]);
    hl_nxt = 64'(mag[63:32]) * 64'(mul_b[31:0]);
  end

  // sum of the partial products, full 128 bits
  always_comb begin
    mid_nxt = dec_r;
    mid_nxt.prod = dec_r.prod + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0};
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_nxt;
    lh_r <= lh_nxt;
    hl_r <= hl_nxt;
    mid_r <= mid_nxt;
  end

endmodule

// ===== src/ibrs_back.sv =====
// ----------------------------------------------------------------------------
// ibrs_back
// rounding, exponent scaling and range check of the product
// ----------------------------------------------------------------------------
module ibrs_back import ibrs_pkg::*; (
  input  ibrs_mid_t    mid,
  output logic         ok,
  output logic [63:0]  value
);

  logic [116:0] dprod;
  logic [6:0]   len;
  logic [4:0]   k;
  logic [116:0] rem_mask;
  logic [116:0] rem;
  logic [116:0] half;
  logic [116:0] shp;
  logic [100:0] rnd;
  logic signed [13:0] e;
  logic [100:0] sc;
  logic [63:0]  mag;
  logic         good;

  always_comb begin
    // a double product never exceeds 117 bits
    dprod = mid.prod[116:0];
    len = 7'd0;
    for (int i = 0; i < 117; i++) begin
      if (dprod[i]) len = 7'(i + 1);
    end
    k = (len > 7'(PREC_BITS)) ? 5'(len - 7'(PREC_BITS)) : 5'd0;
    rem_mask = (117'd1 << k) - 117'd1;
    rem = dprod & rem_mask;
    half = (k == 5'd0) ? 117'd0 : (117'd1 << (k - 5'd1));
    shp = dprod >> k;
    rnd = shp[100:0];
    if (k != 5'd0 && (rem > half || (rem == half && shp[0]))) rnd = rnd + 101'd1;
    e = 14'(mid.exp) + 14'(k);
    good = 1'b1;
    mag = 64'd0;
    sc = 101'd0;
    if (mid.is_int) begin
      mag = mid.prod[63:0];
      if (mid.prod[127:64] != 64'd0 || mag > mid.lim) good = 1'b0;
    end else if (dprod == 117'd0) begin
      mag = 64'd0;
    end else if (e >= 0) begin
      if (e >= 64 || rnd[100:64] != 37'd0 || rnd[63:0] > (mid.lim >> e[5:0])) good = 1'b0;
      mag = rnd[63:0] << e[5:0];
    end else begin
      sc = (e < -14'sd127) ? 101'd0 : (rnd >> 7'(-e));
      if (sc[100:64] != 37'd0 || sc[63:0] > mid.lim) good = 1'b0;
      mag = sc[63:0];
    end
    if (mid.is_int && mid.zero) begin
      ok = 1'b1;
      value = 64'd0;
    end else if (mid.fail || !good) begin
      ok = 1'b0;
      value = mid.cnt;
    end else begin
      ok = 1'b1;
      value = mid.neg ? (64'd0 - mag) : mag;
    end
  end

endmodule
